[hw/rtl/first_fit_heap_allocator_top_assert.svh]
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Implication in the same cycle.
`define FFHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define FFHA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ffha_pkg.sv]
// Shared constants and types of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF  = 1024;
  localparam int unsigned ALIGN_BYTES_DEF = 16;
  localparam int unsigned MAX_BLOCKS_DEF  = 64;
  localparam int unsigned FIELD_W         = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SPLIT,
    ST_MERGE,
    ST_DONE
  } state_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

endpackage

[hw/rtl/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator with split and coalesce.
//
// Input channel (in_valid_i/in_ready_o) takes one request word: kind_i selects
// allocate or free, request_size_i is the allocate size in bytes, address_i the
// payload offset to release. Output channel (out_valid_o/out_ready_i) returns
// one word per request: ok_o and payload_offset_o.
// The heap is a chain of blocks kept in one RAM indexed by granule, one entry
// per header: busy flag and payload length in granules. A request walks the
// chain from granule 0, one header per cycle through the RAM read port.
// After acceptance an allocate walks the headers and, if the block is split,
// writes the header of the split-off free block; a free walks the headers and,
// when the block is found, merges it with its free neighbours. Each request then
// passes the done state. A walk visits at most MAX_BLOCKS headers.
// A finished word sits in the output register; the next request is taken while
// it waits. If the receiver stalls, a second finished word waits in the done
// state until the register drains.
// Reset leaves one free block at granule 0 spanning the heap; granule 0 reads
// its reset value until first written, so no clearing pass is needed.
`include "first_fit_heap_allocator_top_assert.svh"

module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES  = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES = ffha_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS  = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [ffha_pkg::FIELD_W-1:0] request_size_i,
  input  logic [ffha_pkg::FIELD_W-1:0] address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [ffha_pkg::FIELD_W-1:0] payload_offset_o
);

  localparam int unsigned GRANULES = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned GW       = $clog2(GRANULES);
  localparam int unsigned AL       = $clog2(ALIGN_BYTES);
  localparam int unsigned CW       = ((GW > ffha_pkg::FIELD_W) ? GW : ffha_pkg::FIELD_W) + 2;
  localparam int unsigned OW       = ($clog2(HEAP_BYTES) + 1 > ffha_pkg::FIELD_W) ?
                                     $clog2(HEAP_BYTES) + 1 : ffha_pkg::FIELD_W;
  localparam int unsigned SW       = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MW       = GW + 1;

  ffha_pkg::state_e state_q, state_d;

  logic [GW-1:0]  g_q, g_d;
  logic [SW-1:0]  step_q, step_d;
  logic           kind_q, kind_d;
  logic [CW-1:0]  pg_q, pg_d;
  logic [ffha_pkg::FIELD_W-1:0] addr_q, addr_d;
  logic [GW-1:0]  prev_q, prev_d;
  logic [GW-1:0]  prev_cnt_q, prev_cnt_d;
  logic           prev_busy_q, prev_busy_d;
  logic           have_prev_q, have_prev_d;
  logic [GW-1:0]  cnt_q, cnt_d;
  logic           nx_in_q, nx_in_d;
  logic [GW-1:0]  ng_q, ng_d;
  logic [GW-1:0]  split_cnt_q, split_cnt_d;
  logic           res_ok_q, res_ok_d;
  logic [ffha_pkg::FIELD_W-1:0] res_off_q, res_off_d;
  logic           out_valid_q, out_valid_d;
  logic           out_ok_q, out_ok_d;
  logic [ffha_pkg::FIELD_W-1:0] out_off_q, out_off_d;
  logic           init_q, init_d;
  logic           rd0_q, rd0_d;

  logic           re, we;
  logic [GW-1:0]  raddr, waddr;
  logic [MW-1:0]  wdata, ram_rdata, rdata;

  logic           r_busy;
  logic [CW-1:0]  r_cnt, nx, gp1, split_cnt, newc;
  logic [OW-1:0]  off;
  logic           fit, split, match, nx_ok, nxf;

  ffha_ram #(
    .WIDTH (MW),
    .DEPTH (GRANULES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // granule 0 holds the whole heap until its entry is first written
  assign rdata  = (init_q && rd0_q) ? {1'b0, GW'(GRANULES - 1)} : ram_rdata;
  assign r_busy = rdata[GW];
  assign r_cnt  = CW'(rdata[GW-1:0]);
  assign gp1    = CW'(g_q) + CW'(1);
  assign nx     = gp1 + r_cnt;
  assign off    = OW'(gp1) << AL;
  assign fit    = !r_busy && (r_cnt >= pg_q);
  assign split  = (r_cnt >= pg_q + CW'(2)) && (gp1 + pg_q < CW'(GRANULES));
  assign split_cnt = r_cnt - pg_q - CW'(1);
  assign match  = (off == OW'(addr_q));
  assign nx_ok  = (nx < CW'(GRANULES)) && (CW'(step_q) + CW'(1) < CW'(MAX_BLOCKS));
  assign nxf    = nx_in_q && !r_busy;
  assign newc   = CW'(cnt_q) + (nxf ? (CW'(1) + r_cnt) : CW'(0));

  always_comb begin
    state_d     = state_q;
    g_d         = g_q;
    step_d      = step_q;
    kind_d      = kind_q;
    pg_d        = pg_q;
    addr_d      = addr_q;
    prev_d      = prev_q;
    prev_cnt_d  = prev_cnt_q;
    prev_busy_d = prev_busy_q;
    have_prev_d = have_prev_q;
    cnt_d       = cnt_q;
    nx_in_d     = nx_in_q;
    ng_d        = ng_q;
    split_cnt_d = split_cnt_q;
    res_ok_d    = res_ok_q;
    res_off_d   = res_off_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_off_d   = out_off_q;
    in_ready_o  = 1'b0;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ffha_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d      = kind_i;
          pg_d        = (CW'(request_size_i) + CW'(ALIGN_BYTES - 1)) >> AL;
          addr_d      = address_i;
          g_d         = '0;
          step_d      = '0;
          have_prev_d = 1'b0;
          re          = 1'b1;
          raddr       = '0;
          state_d     = ffha_pkg::ST_EVAL;
        end
      end
      ffha_pkg::ST_EVAL: begin
        if (kind_q == ffha_pkg::KIND_ALLOC && fit) begin
          we        = 1'b1;
          waddr     = g_q;
          wdata     = {1'b1, split ? GW'(pg_q) : GW'(r_cnt)};
          res_ok_d  = 1'b1;
          res_off_d = off[ffha_pkg::FIELD_W-1:0];
          ng_d        = GW'(gp1 + pg_q);
          split_cnt_d = GW'(split_cnt);
          state_d   = split ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_DONE;
        end else if (kind_q == ffha_pkg::KIND_FREE && match) begin
          cnt_d     = GW'(r_cnt);
          nx_in_d   = (nx < CW'(GRANULES));
          re        = 1'b1;
          raddr     = GW'(nx);
          res_ok_d  = 1'b1;
          res_off_d = '0;
          state_d   = ffha_pkg::ST_MERGE;
        end else begin
          prev_d      = g_q;
          prev_busy_d = r_busy;
          prev_cnt_d  = GW'(r_cnt);
          have_prev_d = 1'b1;
          if (nx_ok) begin
            re     = 1'b1;
            raddr  = GW'(nx);
            g_d    = GW'(nx);
            step_d = step_q + SW'(1);
          end else begin
            res_ok_d  = 1'b0;
            res_off_d = '0;
            state_d   = ffha_pkg::ST_DONE;
          end
        end
      end
      ffha_pkg::ST_SPLIT: begin
        // new free block header right after the granted payload
        we      = 1'b1;
        waddr   = ng_q;
        wdata   = {1'b0, split_cnt_q};
        state_d = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_MERGE: begin
        we = 1'b1;
        if (have_prev_q && !prev_busy_q) begin
          waddr = prev_q;
          wdata = {1'b0, GW'(CW'(prev_cnt_q) + CW'(1) + newc)};
        end else begin
          waddr = g_q;
          wdata = {1'b0, GW'(newc)};
        end
        state_d = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_off_d   = res_off_q;
          state_d     = ffha_pkg::ST_IDLE;
        end
      end
      default: state_d = ffha_pkg::ST_IDLE;
    endcase

    init_d = init_q && !(we && waddr == '0);
    rd0_d  = re ? (raddr == '0) : rd0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      init_q      <= 1'b1;
      rd0_q       <= 1'b0;
      have_prev_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      init_q      <= init_d;
      rd0_q       <= rd0_d;
      have_prev_q <= have_prev_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q         <= g_d;
    kind_q      <= kind_d;
    pg_q        <= pg_d;
    addr_q      <= addr_d;
    prev_q      <= prev_d;
    prev_cnt_q  <= prev_cnt_d;
    prev_busy_q <= prev_busy_d;
    cnt_q       <= cnt_d;
    nx_in_q     <= nx_in_d;
    ng_q        <= ng_d;
    split_cnt_q <= split_cnt_d;
    res_ok_q    <= res_ok_d;
    res_off_q   <= res_off_d;
    out_ok_q    <= out_ok_d;
    out_off_q   <= out_off_d;
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_ok_q;
  assign payload_offset_o = out_off_q;

  `FFHA_ASSERT_IMP(a_no_write_idle, we, state_q != ffha_pkg::ST_IDLE,
                   "heap RAM written while idle")
  `FFHA_ASSERT_NXT(a_accept_to_eval, in_valid_i && in_ready_o, state_q == ffha_pkg::ST_EVAL,
                   "accepted word did not start a walk")
  `FFHA_ASSERT_IMP(a_walk_bound, state_q == ffha_pkg::ST_EVAL, step_q < SW'(MAX_BLOCKS),
                   "chain walk exceeded block limit")
  `FFHA_ASSERT_IMP(a_done_fill, state_q == ffha_pkg::ST_DONE && !out_valid_q,
                   state_d == ffha_pkg::ST_IDLE, "done state failed to load empty output")

endmodule
